// ===== rtl/sqpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_pkg
// Shared types, queue sizing and saturation helper for the scaled quaternion
// point transform.
// ----------------------------------------------------------------------------
package sqpt_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [31:0] word_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } item_kind_e;

  // quat: 0 = x, 1 = y, 2 = z, 3 = w
  typedef struct packed {
    item_kind_e  kind;
    word_t [3:0] quat;
    word_t [2:0] pos;
    word_t [2:0] scale;
  } q_entry_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } sat_t;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.clip  = 1'b0;
    r.value = v[31:0];
    if (v > MAX32) begin
      r.clip  = 1'b1;
      r.value = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r.clip  = 1'b1;
      r.value = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sqpt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_in_if
// Input channel: load and point transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sqpt_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;

  modport source (
    output valid, op, quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z,
           scale_x, scale_y, scale_z,
    input  ready
  );

  modport sink (
    input  valid, op, quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z,
           scale_x, scale_y, scale_z,
    output ready
  );
endinterface

// ===== rtl/sqpt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_out_if
// Output channel: world position transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sqpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic               saturated;

  modport source (
    output valid, world_x, world_y, world_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, world_x, world_y, world_z, saturated,
    output ready
  );
endinterface

// ===== rtl/sqpt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_front
// Accepts input transactions, tags them as load or point and queues them
// for the execution back end.
// ----------------------------------------------------------------------------
module sqpt_front
  import sqpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sqpt_in_if.sink    in_i,
  output logic       entry_vld_o,
  output q_entry_t   entry_o,
  input  logic       entry_rdy_i
);

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push, pop;
  q_entry_t            entry_new;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_i.ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign entry_vld_o = (count_q != '0);
  assign entry_o     = mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = entry_vld_o && entry_rdy_i;

  always_comb begin
    entry_new.kind     = in_i.op ? KIND_POINT : KIND_LOAD;
    entry_new.quat[0]  = in_i.quat_x;
    entry_new.quat[1]  = in_i.quat_y;
    entry_new.quat[2]  = in_i.quat_z;
    entry_new.quat[3]  = in_i.quat_w;
    entry_new.pos[0]   = in_i.pos_x;
    entry_new.pos[1]   = in_i.pos_y;
    entry_new.pos[2]   = in_i.pos_z;
    entry_new.scale[0] = in_i.scale_x;
    entry_new.scale[1] = in_i.scale_y;
    entry_new.scale[2] = in_i.scale_z;
  end

  always_comb begin
    wr_ptr_d = push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_new;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

// ===== rtl/sqpt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_back
// Executes queued transactions on one shared 32x32 multiplier: builds the
// scaled basis on a load, transforms the point on a point transaction.
// ----------------------------------------------------------------------------
module sqpt_back
  import sqpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       entry_vld_i,
  input  q_entry_t   entry_i,
  output logic       entry_rdy_o,
  sqpt_out_if.source out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QMUL  = 3'd1;
  localparam logic [2:0] ST_QWAIT = 3'd2;
  localparam logic [2:0] ST_SMUL  = 3'd3;
  localparam logic [2:0] ST_SWAIT = 3'd4;
  localparam logic [2:0] ST_PMUL  = 3'd5;
  localparam logic [2:0] ST_PWAIT = 3'd6;
  localparam logic [2:0] ST_PDONE = 3'd7;

  localparam logic [3:0] DP_XX = 4'd0;
  localparam logic [3:0] DP_YY = 4'd1;
  localparam logic [3:0] DP_ZZ = 4'd2;
  localparam logic [3:0] DP_YZ = 4'd3;
  localparam logic [3:0] DP_WX = 4'd4;
  localparam logic [3:0] DP_XY = 4'd5;
  localparam logic [3:0] DP_WZ = 4'd6;
  localparam logic [3:0] DP_XZ = 4'd7;
  localparam logic [3:0] DP_WY = 4'd8;

  localparam logic [3:0] LAST_IDX = 4'd8;
  localparam logic [1:0] LAST_SUB = 2'd2;
  localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;

  localparam logic [1:0] QX = 2'd0;
  localparam logic [1:0] QY = 2'd1;
  localparam logic [1:0] QZ = 2'd2;
  localparam logic [1:0] QW = 2'd3;

  logic [2:0]          state_q, state_d;
  logic [3:0]          idx_q, idx_d;
  logic [1:0]          sub_q, sub_d;
  logic [1:0]          grp_q, grp_d;
  q_entry_t            item_q;
  logic signed [34:0]  dp_q [9];
  word_t               basis_q [9];
  word_t               origin_q [3];
  logic signed [49:0]  acc_q [3];

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_q;
  logic                mul_vld_q;
  logic [2:0]          tag_state_q;
  logic [3:0]          tag_idx_q;
  logic [1:0]          tag_grp_q;

  logic                out_vld_q;
  word_t               world_q [3];
  logic                clip_q;

  logic                issue, pop, out_wr, last_step;
  logic signed [36:0]  term;
  logic [3:0]          bidx;
  sat_t                sat_b;
  logic signed [49:0]  prod_ext;
  sat_t                sat_w [3];

  function automatic logic signed [36:0] sx(input logic signed [34:0] v);
    return {{2{v[34]}}, v};
  endfunction

  assign entry_rdy_o = (state_q == ST_IDLE);
  assign pop         = entry_rdy_o && entry_vld_i;
  assign issue       = (state_q == ST_QMUL) || (state_q == ST_SMUL) || (state_q == ST_PMUL);
  assign last_step   = (idx_q == LAST_IDX);
  assign out_wr      = (state_q == ST_PDONE) && (!out_vld_q || out_o.ready);
  assign bidx        = {1'b0, sub_q, 1'b0} + {2'b0, sub_q} + {2'b0, grp_q};
  assign sat_b       = sat32({{24{prod_q[63]}}, prod_q[63:24]});
  assign prod_ext    = {{2{prod_q[63]}}, prod_q[63:16]};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat_w[j] = sat32({{14{acc_q[j][49]}}, acc_q[j]});
    end
  end

  always_comb begin
    unique case (idx_q)
      4'd0:    term = ONE_Q30 - (sx(dp_q[DP_YY]) + sx(dp_q[DP_ZZ]));
      4'd1:    term = sx(dp_q[DP_XY]) + sx(dp_q[DP_WZ]);
      4'd2:    term = sx(dp_q[DP_XZ]) - sx(dp_q[DP_WY]);
      4'd3:    term = sx(dp_q[DP_XY]) - sx(dp_q[DP_WZ]);
      4'd4:    term = ONE_Q30 - (sx(dp_q[DP_XX]) + sx(dp_q[DP_ZZ]));
      4'd5:    term = sx(dp_q[DP_YZ]) + sx(dp_q[DP_WX]);
      4'd6:    term = sx(dp_q[DP_XZ]) + sx(dp_q[DP_WY]);
      4'd7:    term = sx(dp_q[DP_YZ]) - sx(dp_q[DP_WX]);
      4'd8:    term = ONE_Q30 - (sx(dp_q[DP_XX]) + sx(dp_q[DP_YY]));
      default: term = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_QMUL: begin
        unique case (idx_q)
          DP_XX: begin mul_a = $signed(item_q.quat[QX]); mul_b = $signed(item_q.quat[QX]); end
          DP_YY: begin mul_a = $signed(item_q.quat[QY]); mul_b = $signed(item_q.quat[QY]); end
          DP_ZZ: begin mul_a = $signed(item_q.quat[QZ]); mul_b = $signed(item_q.quat[QZ]); end
          DP_YZ: begin mul_a = $signed(item_q.quat[QY]); mul_b = $signed(item_q.quat[QZ]); end
          DP_WX: begin mul_a = $signed(item_q.quat[QW]); mul_b = $signed(item_q.quat[QX]); end
          DP_XY: begin mul_a = $signed(item_q.quat[QX]); mul_b = $signed(item_q.quat[QY]); end
          DP_WZ: begin mul_a = $signed(item_q.quat[QW]); mul_b = $signed(item_q.quat[QZ]); end
          DP_XZ: begin mul_a = $signed(item_q.quat[QX]); mul_b = $signed(item_q.quat[QZ]); end
          DP_WY: begin mul_a = $signed(item_q.quat[QW]); mul_b = $signed(item_q.quat[QY]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SMUL: begin
        mul_a = $signed({term[36], term[36:6]});
        mul_b = $signed(item_q.scale[grp_q]);
      end
      ST_PMUL: begin
        mul_a = $signed(item_q.pos[sub_q]);
        mul_b = basis_q[bidx];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sub_d   = sub_q;
    grp_d   = grp_q;
    if (issue) begin
      idx_d = idx_q + 1'b1;
      if (sub_q == LAST_SUB) begin
        sub_d = '0;
        grp_d = grp_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        sub_d = '0;
        grp_d = '0;
        if (pop) begin
          state_d = (entry_i.kind == KIND_POINT) ? ST_PMUL : ST_QMUL;
        end
      end
      ST_QMUL:  if (last_step) state_d = ST_QWAIT;
      ST_QWAIT: begin
        idx_d   = '0;
        sub_d   = '0;
        grp_d   = '0;
        state_d = ST_SMUL;
      end
      ST_SMUL:  if (last_step) state_d = ST_SWAIT;
      ST_SWAIT: state_d = ST_IDLE;
      ST_PMUL:  if (last_step) state_d = ST_PWAIT;
      ST_PWAIT: state_d = ST_PDONE;
      ST_PDONE: if (out_wr) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      sub_q       <= '0;
      grp_q       <= '0;
      mul_vld_q   <= 1'b0;
      tag_state_q <= ST_IDLE;
      tag_idx_q   <= '0;
      tag_grp_q   <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < 9; i++) basis_q[i] <= '0;
      for (int i = 0; i < 3; i++) origin_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      grp_q       <= grp_d;
      mul_vld_q   <= issue;
      tag_state_q <= state_q;
      tag_idx_q   <= idx_q;
      tag_grp_q   <= grp_q;
      if (out_wr) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (pop && entry_i.kind == KIND_LOAD) begin
        for (int i = 0; i < 3; i++) origin_q[i] <= entry_i.pos[i];
      end
      if (mul_vld_q && tag_state_q == ST_SMUL) begin
        basis_q[tag_idx_q] <= sat_b.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop) begin
      item_q <= entry_i;
      for (int j = 0; j < 3; j++) acc_q[j] <= {{18{origin_q[j][31]}}, origin_q[j]};
    end else if (mul_vld_q && tag_state_q == ST_PMUL) begin
      acc_q[tag_grp_q] <= acc_q[tag_grp_q] + prod_ext;
    end
    if (mul_vld_q && tag_state_q == ST_QMUL) begin
      dp_q[tag_idx_q] <= $signed({prod_q[63:30], 1'b0});
    end
    if (out_wr) begin
      for (int j = 0; j < 3; j++) world_q[j] <= sat_w[j].value;
      clip_q <= sat_w[0].clip | sat_w[1].clip | sat_w[2].clip;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.world_x   = world_q[0];
  assign out_o.world_y   = world_q[1];
  assign out_o.world_z   = world_q[2];
  assign out_o.saturated = clip_q;

  a_qwait_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QWAIT |-> mul_vld_q && tag_state_q == ST_QMUL && tag_idx_q == LAST_IDX)
    else $error("last quaternion product not in flight at wait step");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PDONE |-> !mul_vld_q)
    else $error("product still in flight when point result is formed");

  a_mul_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> ($past(state_q) == ST_QMUL || $past(state_q) == ST_SMUL ||
                   $past(state_q) == ST_PMUL))
    else $error("product tagged valid without a multiply step");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> idx_q <= LAST_IDX)
    else $error("step counter past last product");

endmodule

// ===== rtl/scaled_quat_point_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_quat_point_transform_unit
// Scaled quaternion parent transform applied to local points, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries transactions. op = 0 loads a parent transform (quaternion
//   Q2.30, translation, per-axis scale Q16.16) and gives no result. op = 1
//   transforms a local point; one world position with a saturation flag
//   leaves on out_o per point.
//   A two-entry queue decouples acceptance from execution. The back end runs
//   one transaction at a time on a single 32x32 multiplier with a registered
//   product, and it takes no new transaction until the last is done. A load
//   steps through pop, nine quaternion products, drain, nine scaled basis
//   entries and drain; a point steps through pop, nine products, drain, and
//   saturate and output write, which waits while out_o stalls. Transactions
//   complete in arrival order; a point after a load sees the new transform.
//   Reset clears the basis and translation to zero, so points before any
//   load give zero. When out_o stalls, the result is held in the output
//   register and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module scaled_quat_point_transform_unit
  import sqpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sqpt_in_if.sink    in_i,
  sqpt_out_if.source out_o
);

  logic     entry_vld;
  logic     entry_rdy;
  q_entry_t entry;

  sqpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .entry_vld_o (entry_vld),
    .entry_o     (entry),
    .entry_rdy_i (entry_rdy)
  );

  sqpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_vld_i (entry_vld),
    .entry_i     (entry),
    .entry_rdy_o (entry_rdy),
    .out_o       (out_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scaled_quat_point_transform_unit. It runs a table
// of directed load and point transactions, then random load-then-points
// groups. Sender and receiver gaps are random, and the receiver holds off
// once for a long stretch so that the input stalls. An in-bench fixed-point
// model of the basis build and the point transform predicts each world
// position the table does not give, and all are compared in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import sqpt_pkg::*;

  localparam word_t MAXW      = 32'sh7FFF_FFFF;
  localparam word_t MINW      = 32'sh8000_0000;
  localparam word_t ONE_Q30   = 32'sh4000_0000;
  localparam word_t UNIT_Q16  = 32'sh0001_0000;
  localparam word_t COS45_Q30 = 32'sh2D41_3CCD;

  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  localparam int unsigned QUAT_SPAN  = 32'h4000_0000;
  localparam int unsigned SCALE_SPAN = 32'h0004_0000;
  localparam int unsigned POS_SPAN   = 32'h0010_0000;

  localparam int TOTAL_ITEMS  = 1750;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    item_kind_e kind;
    word_t      qx, qy, qz, qw;
    word_t      px, py, pz;
    word_t      sx, sy, sz;
  } xform_item_t;

  typedef struct packed {
    word_t wx, wy, wz;
    logic  sat;
  } world_pos_t;

  typedef struct packed {
    xform_item_t item;
    logic        has_exp;
    world_pos_t  world;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{KIND_POINT, '0, '0, '0, '0, MAXW, MAXW, MAXW, '0, '0, '0},
      1'b1, '{'0, '0, '0, 1'b0}},
    '{'{KIND_POINT, '0, '0, '0, '0, MINW, MINW, MINW, '0, '0, '0},
      1'b1, '{'0, '0, '0, 1'b0}},
    '{'{KIND_LOAD, '0, '0, '0, ONE_Q30, 32'sh100, 32'sh200, -32'sh300,
        UNIT_Q16, UNIT_Q16, UNIT_Q16}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh100, 32'sh200, 32'sh300, '0, '0, '0},
      1'b1, '{32'sh200, 32'sh400, '0, 1'b0}},
    '{'{KIND_POINT, '0, '0, '0, '0, MAXW, MAXW, MAXW, '0, '0, '0},
      1'b1, '{MAXW, MAXW, 32'sh7FFF_FCFF, 1'b1}},
    '{'{KIND_POINT, '0, '0, '0, '0, MINW, MINW, MINW, '0, '0, '0},
      1'b1, '{32'sh8000_0100, 32'sh8000_0200, MINW, 1'b1}},
    '{'{KIND_POINT, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      1'b1, '{32'sh100, 32'sh200, -32'sh300, 1'b0}},
    '{'{KIND_LOAD, '0, '0, '0, ONE_Q30, MINW, MAXW, '0, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh1234_5678, MINW, MAXW, '0, '0, '0},
      1'b1, '{MINW, MAXW, '0, 1'b0}},
    '{'{KIND_LOAD, MINW, MINW, MINW, MINW, '0, '0, '0, MAXW, MAXW, MAXW},
      1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh100, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, MAXW, MINW, MAXW, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_LOAD, MAXW, MAXW, MAXW, MAXW, 32'sh1000, -32'sh1000, 32'sh7FFF_0000,
        MINW, MINW, MINW}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, -32'sh100, 32'sh100, MAXW, '0, '0, '0},
      1'b0, '0},
    '{'{KIND_LOAD, ONE_Q30, ONE_Q30, '0, '0, '0, '0, '0,
        32'sh2_0000, UNIT_Q16, 32'sh8000}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh100, 32'sh200, 32'sh300, '0, '0, '0},
      1'b0, '0},
    '{'{KIND_LOAD, '0, '0, COS45_Q30, COS45_Q30, 32'sh500, '0, -32'sh80,
        -UNIT_Q16, UNIT_Q16, UNIT_Q16}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh100, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, -32'sh7FFF, 32'sh3FFF_FFFF, 32'sh1, '0, '0, '0},
      1'b0, '0},
    '{'{KIND_LOAD, '0, -ONE_Q30, '0, '0, MAXW, MAXW, MAXW,
        32'sh3_0000, -32'sh2_0000, MAXW}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh100, 32'sh100, 32'sh100, '0, '0, '0},
      1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, MINW, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_LOAD, MAXW, MINW, MAXW, MINW, '0, '0, '0, 32'sh1, -32'sh1, MINW},
      1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, MAXW, MAXW, MAXW, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_POINT, '0, '0, '0, '0, 32'sh1, -32'sh1, 32'sh1, '0, '0, '0}, 1'b0, '0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sqpt_in_if  in_ch ();
  sqpt_out_if out_ch ();

  scaled_quat_point_transform_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  word_t      basis_q16  [9] = '{default: '0};
  word_t      origin_pos [3] = '{default: '0};
  world_pos_t pending_world [$];

  int   items_sent   = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  logic tx_burst     = 1'b0;
  logic rx_burst     = 1'b0;

  function automatic word_t clip_word(input logic signed [63:0] v, output logic hit);
    hit = 1'b0;
    if (v > WIDE_MAX) begin
      hit = 1'b1;
      return MAXW;
    end
    if (v < WIDE_MIN) begin
      hit = 1'b1;
      return MINW;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] dbl_prod(input word_t a, input word_t b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return ((wa * wb) >>> 30) <<< 1;
  endfunction

  function automatic word_t scaled_entry(input logic signed [63:0] term, input word_t scale);
    logic signed [63:0] s64;
    logic               hit;
    s64 = scale;
    return clip_word(((term >>> 6) * s64) >>> 24, hit);
  endfunction

  function automatic void load_parent(input xform_item_t it);
    logic signed [63:0] xx, yy, zz, yz, wx, xy, wz, xz, wy, one;
    one = 64'sd1 <<< 30;
    xx  = dbl_prod(it.qx, it.qx);
    yy  = dbl_prod(it.qy, it.qy);
    zz  = dbl_prod(it.qz, it.qz);
    yz  = dbl_prod(it.qy, it.qz);
    wx  = dbl_prod(it.qw, it.qx);
    xy  = dbl_prod(it.qx, it.qy);
    wz  = dbl_prod(it.qw, it.qz);
    xz  = dbl_prod(it.qx, it.qz);
    wy  = dbl_prod(it.qw, it.qy);
    basis_q16[0] = scaled_entry(one - (yy + zz), it.sx);
    basis_q16[1] = scaled_entry(xy + wz, it.sx);
    basis_q16[2] = scaled_entry(xz - wy, it.sx);
    basis_q16[3] = scaled_entry(xy - wz, it.sy);
    basis_q16[4] = scaled_entry(one - (xx + zz), it.sy);
    basis_q16[5] = scaled_entry(yz + wx, it.sy);
    basis_q16[6] = scaled_entry(xz + wy, it.sz);
    basis_q16[7] = scaled_entry(yz - wx, it.sz);
    basis_q16[8] = scaled_entry(one - (xx + yy), it.sz);
    origin_pos[0] = it.px;
    origin_pos[1] = it.py;
    origin_pos[2] = it.pz;
  endfunction

  function automatic world_pos_t world_of_point(input xform_item_t it);
    logic signed [63:0] p [3];
    logic signed [63:0] acc, b;
    logic               hit;
    word_t              w [3];
    world_pos_t         res;
    p[0] = it.px;
    p[1] = it.py;
    p[2] = it.pz;
    res.sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      acc = origin_pos[j];
      for (int k = 0; k < 3; k++) begin
        b = basis_q16[k * 3 + j];
        acc += (p[k] * b) >>> 16;
      end
      w[j] = clip_word(acc, hit);
      res.sat |= hit;
    end
    res.wx = w[0];
    res.wy = w[1];
    res.wz = w[2];
    return res;
  endfunction

  function automatic word_t draw_word(input int unsigned span);
    case ($urandom_range(0, 9))
      6, 7, 8: return $urandom;
      9: begin
        case ($urandom_range(0, 4))
          0:       return MAXW;
          1:       return MINW;
          2:       return '0;
          3:       return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic xform_item_t random_item(input item_kind_e kind);
    xform_item_t it;
    it.kind = kind;
    it.qx   = draw_word(QUAT_SPAN);
    it.qy   = draw_word(QUAT_SPAN);
    it.qz   = draw_word(QUAT_SPAN);
    it.qw   = draw_word(QUAT_SPAN);
    it.px   = draw_word(POS_SPAN);
    it.py   = draw_word(POS_SPAN);
    it.pz   = draw_word(POS_SPAN);
    it.sx   = draw_word(SCALE_SPAN);
    it.sy   = draw_word(SCALE_SPAN);
    it.sz   = draw_word(SCALE_SPAN);
    return it;
  endfunction

  task automatic offer_item(input xform_item_t it, input logic has_exp,
                            input world_pos_t exp_world);
    int gap;
    if ($urandom_range(0, 99) < 3) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= it.kind;
    in_ch.quat_x  <= it.qx;
    in_ch.quat_y  <= it.qy;
    in_ch.quat_z  <= it.qz;
    in_ch.quat_w  <= it.qw;
    in_ch.pos_x   <= it.px;
    in_ch.pos_y   <= it.py;
    in_ch.pos_z   <= it.pz;
    in_ch.scale_x <= it.sx;
    in_ch.scale_y <= it.sy;
    in_ch.scale_z <= it.sz;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (it.kind == KIND_LOAD) begin
      load_parent(it);
    end else begin
      pending_world.push_back(has_exp ? exp_world : world_of_point(it));
    end
  endtask

  task automatic take_result();
    world_pos_t got, want;
    got.wx  = out_ch.world_x;
    got.wy  = out_ch.world_y;
    got.wz  = out_ch.world_z;
    got.sat = out_ch.saturated;
    results_seen++;
    if (pending_world.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("result %0d unexpected: %h %h %h sat %b",
                 results_seen, got.wx, got.wy, got.wz, got.sat);
      end
    end else begin
      want = pending_world.pop_front();
      if (got.wx !== want.wx || got.wy !== want.wy || got.wz !== want.wz ||
          got.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d: expected %h %h %h sat %b, got %h %h %h sat %b",
                   results_seen, want.wx, want.wy, want.wz, want.sat,
                   got.wx, got.wy, got.wz, got.sat);
        end
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 99) < 3) rx_burst = !rx_burst;
      if (results_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      take_result();
    end
  end

  initial begin : stimulus
    int n_points;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= KIND_LOAD;
    in_ch.quat_x  <= '0;
    in_ch.quat_y  <= '0;
    in_ch.quat_z  <= '0;
    in_ch.quat_w  <= '0;
    in_ch.pos_x   <= '0;
    in_ch.pos_y   <= '0;
    in_ch.pos_z   <= '0;
    in_ch.scale_x <= '0;
    in_ch.scale_y <= '0;
    in_ch.scale_z <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      offer_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].has_exp, DIRECTED_ROWS[i].world);
    end

    // one load, then a run of points against it; drop the run now and then
    while (items_sent < TOTAL_ITEMS) begin
      n_points = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      offer_item(random_item(KIND_LOAD), 1'b0, '0);
      repeat (n_points) offer_item(random_item(KIND_POINT), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_world.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sqpt_pkg.sv
rtl/sqpt_in_if.sv
rtl/sqpt_out_if.sv
rtl/sqpt_front.sv
rtl/sqpt_back.sv
rtl/scaled_quat_point_transform_unit.sv
test/tb.sv
